// ----- hdl/page_number_label_formatter_assert.svh -----
// ----------------------------------------------------------------------------
// page number label formatter assertion macros
// shorthand for clocked implication checks with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef PAGE_NUMBER_LABEL_FORMATTER_ASSERT_SVH
`define PAGE_NUMBER_LABEL_FORMATTER_ASSERT_SVH

// same-cycle implication
`define PNLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnlf: same-cycle check failed");

// next-cycle implication
`define PNLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnlf: next-cycle check failed");

`endif

// ----- hdl/pnlf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnlf_pkg
// beat types, style codes and the constant value table of the formatter
// ----------------------------------------------------------------------------
`default_nettype none

package pnlf_pkg;

    localparam int IDX_W = 6;

    typedef struct packed {
        logic [2:0]  style;
        logic [31:0] position;
    } t_in;

    typedef struct packed {
        logic [6:0] char_code;
        logic       has_char;
        logic       last;
        logic       overflow;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out beat;
    } t_emit;

    typedef struct packed {
        logic       two;
        logic [6:0] c0;
        logic [6:0] c1;
    } t_sym;

    localparam logic [2:0] STYLE_DEC      = 3'd0;
    localparam logic [2:0] STYLE_UP_LET   = 3'd1;
    localparam logic [2:0] STYLE_LO_LET   = 3'd2;
    localparam logic [2:0] STYLE_UP_ROM   = 3'd3;
    localparam logic [2:0] STYLE_LO_ROM   = 3'd4;

    // table layout
    localparam logic [IDX_W-1:0] IDX_ROM_FIRST = 6'd0;
    localparam logic [IDX_W-1:0] IDX_DEC_FIRST = 6'd25;
    localparam logic [IDX_W-1:0] IDX_DEC_LAST  = 6'd34;
    localparam logic [IDX_W-1:0] IDX_LET_LAST  = 6'd41;
    localparam logic [IDX_W-1:0] IDX_LET_ONE   = 6'd40;
    localparam logic [IDX_W-1:0] IDX_LET_LIM   = 6'd42;
    localparam logic [IDX_W-1:0] IDX_ROM_LIM   = 6'd43;

    localparam logic [2:0] LET_MAX_LEN = 3'd7;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_AT    = 7'h40;
    localparam logic [6:0] CH_A_UP  = 7'h41;
    localparam logic [6:0] CH_A_LO  = 7'h61;
    localparam logic [6:0] CASE_BIT = 7'h20;
    localparam logic [6:0] CH_NONE  = 7'h00;

    localparam logic [6:0] CH_UM = 7'h4D;
    localparam logic [6:0] CH_UD = 7'h44;
    localparam logic [6:0] CH_UC = 7'h43;
    localparam logic [6:0] CH_UL = 7'h4C;
    localparam logic [6:0] CH_UX = 7'h58;
    localparam logic [6:0] CH_UV = 7'h56;
    localparam logic [6:0] CH_UI = 7'h49;
    localparam logic [6:0] CH_LM = 7'h6D;
    localparam logic [6:0] CH_LD = 7'h64;
    localparam logic [6:0] CH_LC = 7'h63;
    localparam logic [6:0] CH_LL = 7'h6C;
    localparam logic [6:0] CH_LX = 7'h78;
    localparam logic [6:0] CH_LV = 7'h76;

    function automatic logic [31:0] tab_value(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'd1000000;
            6'd1:  v = 32'd900000;
            6'd2:  v = 32'd500000;
            6'd3:  v = 32'd400000;
            6'd4:  v = 32'd100000;
            6'd5:  v = 32'd90000;
            6'd6:  v = 32'd50000;
            6'd7:  v = 32'd40000;
            6'd8:  v = 32'd10000;
            6'd9:  v = 32'd9000;
            6'd10: v = 32'd5000;
            6'd11: v = 32'd4000;
            6'd12: v = 32'd1000;
            6'd13: v = 32'd900;
            6'd14: v = 32'd500;
            6'd15: v = 32'd400;
            6'd16: v = 32'd100;
            6'd17: v = 32'd90;
            6'd18: v = 32'd50;
            6'd19: v = 32'd40;
            6'd20: v = 32'd10;
            6'd21: v = 32'd9;
            6'd22: v = 32'd5;
            6'd23: v = 32'd4;
            6'd24: v = 32'd1;
            6'd25: v = 32'd1000000000;
            6'd26: v = 32'd100000000;
            6'd27: v = 32'd10000000;
            6'd28: v = 32'd1000000;
            6'd29: v = 32'd100000;
            6'd30: v = 32'd10000;
            6'd31: v = 32'd1000;
            6'd32: v = 32'd100;
            6'd33: v = 32'd10;
            6'd34: v = 32'd1;
            6'd35: v = 32'd308915776;
            6'd36: v = 32'd11881376;
            6'd37: v = 32'd456976;
            6'd38: v = 32'd17576;
            6'd39: v = 32'd676;
            6'd40: v = 32'd26;
            6'd41: v = 32'd1;
            6'd42: v = 32'd4058115286;
            6'd43: v = 32'd4000000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_sym roman_sym(input logic [IDX_W-1:0] idx);
        t_sym s;
        case (idx)
            6'd0:  s = '{1'b0, CH_LM, CH_NONE};
            6'd1:  s = '{1'b1, CH_LC, CH_LM};
            6'd2:  s = '{1'b0, CH_LD, CH_NONE};
            6'd3:  s = '{1'b1, CH_LC, CH_LD};
            6'd4:  s = '{1'b0, CH_LC, CH_NONE};
            6'd5:  s = '{1'b1, CH_LX, CH_LC};
            6'd6:  s = '{1'b0, CH_LL, CH_NONE};
            6'd7:  s = '{1'b1, CH_LX, CH_LL};
            6'd8:  s = '{1'b0, CH_LX, CH_NONE};
            6'd9:  s = '{1'b1, CH_UM, CH_LX};
            6'd10: s = '{1'b0, CH_LV, CH_NONE};
            6'd11: s = '{1'b1, CH_UM, CH_LV};
            6'd12: s = '{1'b0, CH_UM, CH_NONE};
            6'd13: s = '{1'b1, CH_UC, CH_UM};
            6'd14: s = '{1'b0, CH_UD, CH_NONE};
            6'd15: s = '{1'b1, CH_UC, CH_UD};
            6'd16: s = '{1'b0, CH_UC, CH_NONE};
            6'd17: s = '{1'b1, CH_UX, CH_UC};
            6'd18: s = '{1'b0, CH_UL, CH_NONE};
            6'd19: s = '{1'b1, CH_UX, CH_UL};
            6'd20: s = '{1'b0, CH_UX, CH_NONE};
            6'd21: s = '{1'b1, CH_UI, CH_UX};
            6'd22: s = '{1'b0, CH_UV, CH_NONE};
            6'd23: s = '{1'b1, CH_UI, CH_UV};
            default: s = '{1'b0, CH_UI, CH_NONE};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pnlf_alu.sv -----
// ----------------------------------------------------------------------------
// pnlf_alu
// shared subtract and compare unit used for every digit and symbol step
// ----------------------------------------------------------------------------
`default_nettype none

module pnlf_alu (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_diff,
    output logic             o_ge
);

    logic [32:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[31:0];
    assign o_ge   = ~w_sub[32];

endmodule

`default_nettype wire

// ----- hdl/pnlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pnlf_ctrl
// sequencer: walks the value table through the shared unit, at most one beat a step
// ----------------------------------------------------------------------------
`default_nettype none

module pnlf_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire pnlf_pkg::t_in i_item,
    output logic              o_busy,
    output pnlf_pkg::t_emit   o_emit
);

    import pnlf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_LCHK = 3'd2;
    localparam logic [2:0] S_LLEN = 3'd3;
    localparam logic [2:0] S_LDIG = 3'd4;
    localparam logic [2:0] S_RCHK = 3'd5;
    localparam logic [2:0] S_ROM  = 3'd6;
    localparam logic [2:0] S_ONE  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [31:0]      r_v, n_v;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [4:0]       r_d, n_d;
    logic [2:0]       r_len, n_len;
    logic             r_j, n_j;
    logic             r_started, n_started;
    logic             r_lower, n_lower;
    t_out             r_one, n_one;

    logic [31:0] w_diff;
    logic        w_ge;
    t_sym        w_sym;
    logic [6:0]  w_rch;

    pnlf_alu u_alu (
        .i_a    (r_v),
        .i_b    (tab_value(r_idx)),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_sym = roman_sym(r_idx);

    always_comb begin
        w_rch = r_j ? w_sym.c1 : w_sym.c0;
        if (r_lower) begin
            w_rch = w_rch | CASE_BIT;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_idx     = r_idx;
        n_d       = r_d;
        n_len     = r_len;
        n_j       = r_j;
        n_started = r_started;
        n_lower   = r_lower;
        n_one     = r_one;
        o_emit    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lower = (i_item.style == STYLE_LO_LET) || (i_item.style == STYLE_LO_ROM);
                    n_d       = 5'd0;
                    n_j       = 1'b0;
                    n_started = 1'b0;
                    n_one     = '{CH_NONE, 1'b0, 1'b1, 1'b0};
                    case (i_item.style)
                        STYLE_DEC: begin
                            n_v     = i_item.position;
                            n_idx   = IDX_DEC_FIRST;
                            n_state = S_DEC;
                        end
                        STYLE_UP_LET, STYLE_LO_LET: begin
                            n_v     = i_item.position - 32'd1;
                            n_idx   = IDX_LET_LIM;
                            n_state = S_LCHK;
                        end
                        STYLE_UP_ROM, STYLE_LO_ROM: begin
                            n_v     = i_item.position;
                            n_idx   = IDX_ROM_LIM;
                            n_state = S_RCHK;
                        end
                        default: begin
                            n_state = S_ONE;
                        end
                    endcase
                end
            end
            S_DEC: begin
                if (w_ge) begin
                    n_v = w_diff;
                    n_d = r_d + 5'd1;
                end else begin
                    if ((r_d != 5'd0) || r_started || (r_idx == IDX_DEC_LAST)) begin
                        o_emit.valid          = 1'b1;
                        o_emit.beat.char_code = CH_ZERO + 7'(r_d);
                        o_emit.beat.has_char  = 1'b1;
                        o_emit.beat.last      = (r_idx == IDX_DEC_LAST);
                    end
                    n_started = r_started || (r_d != 5'd0);
                    n_d       = 5'd0;
                    n_idx     = r_idx + 6'd1;
                    if (r_idx == IDX_DEC_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LCHK: begin
                if (w_ge) begin
                    n_one   = '{CH_AT, 1'b1, 1'b1, 1'b0};
                    n_state = S_ONE;
                end else begin
                    n_idx   = IDX_LET_ONE;
                    n_len   = 3'd1;
                    n_state = S_LLEN;
                end
            end
            S_LLEN: begin
                if (w_ge && (r_len < LET_MAX_LEN)) begin
                    n_v   = w_diff;
                    n_len = r_len + 3'd1;
                    n_idx = r_idx - 6'd1;
                end else begin
                    n_idx   = r_idx + 6'd1;
                    n_d     = 5'd0;
                    n_state = S_LDIG;
                end
            end
            S_LDIG: begin
                if (w_ge) begin
                    n_v = w_diff;
                    n_d = r_d + 5'd1;
                end else begin
                    o_emit.valid          = 1'b1;
                    o_emit.beat.char_code = (r_lower ? CH_A_LO : CH_A_UP) + 7'(r_d);
                    o_emit.beat.has_char  = 1'b1;
                    o_emit.beat.last      = (r_idx == IDX_LET_LAST);
                    n_d   = 5'd0;
                    n_idx = r_idx + 6'd1;
                    if (r_idx == IDX_LET_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RCHK: begin
                if (w_ge) begin
                    n_one   = '{CH_NONE, 1'b0, 1'b1, 1'b1};
                    n_state = S_ONE;
                end else if (r_v == 32'd0) begin
                    n_state = S_ONE;
                end else begin
                    n_idx   = IDX_ROM_FIRST;
                    n_j     = 1'b0;
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                if (w_ge) begin
                    o_emit.valid          = 1'b1;
                    o_emit.beat.char_code = w_rch;
                    o_emit.beat.has_char  = 1'b1;
                    if (w_sym.two && !r_j) begin
                        n_j = 1'b1;
                    end else begin
                        o_emit.beat.last = (w_diff == 32'd0);
                        n_v = w_diff;
                        n_j = 1'b0;
                        if (w_diff == 32'd0) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
            S_ONE: begin
                o_emit.valid = 1'b1;
                o_emit.beat  = r_one;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_v       <= n_v;
        r_idx     <= n_idx;
        r_d       <= n_d;
        r_len     <= n_len;
        r_j       <= n_j;
        r_started <= n_started;
        r_lower   <= n_lower;
        r_one     <= n_one;
    end

endmodule

`default_nettype wire

// ----- hdl/page_number_label_formatter.sv -----
// ----------------------------------------------------------------------------
// page_number_label_formatter
// formats a page position as decimal, letter or roman label, at most one
// character per result beat
//
// channel   direction  handshake        payload
// item      in         start / busy     i_item (style, position)
// result    out        o_strobe         o_result (char_code, has_char, last,
//                                                  overflow)
//
// the single subtract-compare unit counts every digit by repeated
// subtraction of table values, one step a cycle
// a result beat appears in the cycle after the step that produces it
// busy stays high from acceptance until the step that emits the last beat
// synchronous active-low reset returns the sequencer to idle and clears the
// strobe; results cannot be held off by the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module page_number_label_formatter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pnlf_pkg::t_in i_item,
    output logic               o_strobe,
    output pnlf_pkg::t_out     o_result
);

    import pnlf_pkg::*;

    t_emit w_emit;
    logic  r_strobe;
    t_out  r_result;

    pnlf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_emit  (w_emit)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_emit.valid;
        end
        if (w_emit.valid) begin
            r_result <= w_emit.beat;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hdl/pnlf_checker.sv -----
// ----------------------------------------------------------------------------
// pnlf_checker
// port-level checks of the formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_number_label_formatter_assert.svh"

module pnlf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_strobe,
    input wire pnlf_pkg::t_out o_result
);

    import pnlf_pkg::*;

    logic w_accept;
    logic w_empty;
    logic w_null_last;
    logic w_ovf;
    logic w_mid;

    assign w_accept    = start && !busy;
    assign w_empty     = o_strobe && !o_result.has_char;
    assign w_null_last = o_result.last && (o_result.char_code == CH_NONE);
    assign w_ovf       = o_strobe && o_result.overflow;
    assign w_mid       = o_strobe && !o_result.last;

    // an empty label is a single closing beat with a null code
    `PNLF_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, w_empty, w_null_last)
    // overflow only on an empty roman label
    `PNLF_ASSERT_IMP(a_ovf_empty, i_clk, i_rst_n, w_ovf, !o_result.has_char)
    // more beats still to come keep the block busy
    `PNLF_ASSERT_IMP(a_busy_mid, i_clk, i_rst_n, w_mid, busy)
    // an accepted item always occupies the sequencer
    `PNLF_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)

endmodule

bind page_number_label_formatter pnlf_checker u_pnlf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
